// ===== rtl/core/pal_pkg.sv =====
package pal_pkg;

  localparam int COORD_BITS = 24;
  localparam int SUM_BITS   = 40;

  // chord magnitude needs one more bit than a coordinate
  localparam int ROOT_BITS = COORD_BITS + 1;
  localparam int SQ_BITS   = 2 * COORD_BITS;
  localparam int SSQ_BITS  = SQ_BITS + 1;
  localparam int RAD_BITS  = 2 * ROOT_BITS;
  localparam int ACC_BITS  = ((SUM_BITS > ROOT_BITS) ? SUM_BITS : ROOT_BITS) + 1;
  localparam int CNT_BITS  = $clog2(ROOT_BITS + 1);

  localparam logic [SUM_BITS-1:0] SUM_MAX     = {SUM_BITS{1'b1}};
  localparam logic [ACC_BITS-1:0] SUM_MAX_EXT = ACC_BITS'(SUM_MAX);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_LOAD,
    ST_ROOT,
    ST_SUM
  } pal_state_t;

  typedef struct packed {
    logic go;
    logic start;
  } acc_cmd_t;

endpackage

// ===== rtl/core/pal_if.sv =====
interface pal_in_if;
  import pal_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_coord;
  logic signed [COORD_BITS-1:0] y_coord;
  logic                         start_line;

  modport source (output valid, output x_coord, output y_coord, output start_line,
                  input ready);
  modport sink   (input valid, input x_coord, input y_coord, input start_line,
                  output ready);
endinterface

interface pal_out_if;
  import pal_pkg::*;

  logic                valid;
  logic                ready;
  logic [SUM_BITS-1:0] arc_length;
  logic                length_saturated;

  modport source (output valid, output arc_length, output length_saturated,
                  input ready);
  modport sink   (input valid, input arc_length, input length_saturated,
                  output ready);
endinterface

// ===== rtl/core/polyline_arc_length_accumulator.sv =====
// channel   dir  fields                               handshake
// in_chan   in   x_coord, y_coord, start_line         valid/ready
// out_chan  out  arc_length, length_saturated         valid/ready
//
// A point with start_line goes from idle straight to the sum state; any other point
// passes through the square, load, root and sum states, the root state set by the
// bit-serial square root that yields one root bit per cycle.
// One point is in work at a time; in_chan.ready is high only while idle.
// The result register lets the next point enter while a request waits on out_chan.
// Reset is synchronous, active low, and clears the stored point and length.
module polyline_arc_length_accumulator (
  input  logic      clk,
  input  logic      rst_n,
  pal_in_if.sink    in_chan,
  pal_out_if.source out_chan
);
  import pal_pkg::*;

  pal_state_t state_r, state_nxt;

  logic [COORD_BITS-1:0] prev_x_r, prev_x_nxt;
  logic [COORD_BITS-1:0] prev_y_r, prev_y_nxt;
  logic [COORD_BITS-1:0] dx_r, dx_nxt;
  logic [COORD_BITS-1:0] dy_r, dy_nxt;
  logic [SQ_BITS-1:0]    sqx_r, sqy_r;
  logic                  start_r, start_nxt;

  logic [COORD_BITS:0]   diff_x, diff_y, neg_x, neg_y;
  logic [SQ_BITS-1:0]    dx_ext, dy_ext;
  logic [SSQ_BITS-1:0]   sum_sq;
  logic                  sq_start;
  logic                  sq_busy;
  logic [ROOT_BITS-1:0]  sq_root;
  logic [ROOT_BITS-1:0]  chord;
  logic                  acc_free;
  acc_cmd_t              acc_cmd;

  assign diff_x = {in_chan.x_coord[COORD_BITS-1], in_chan.x_coord}
                - {prev_x_r[COORD_BITS-1], prev_x_r};
  assign diff_y = {in_chan.y_coord[COORD_BITS-1], in_chan.y_coord}
                - {prev_y_r[COORD_BITS-1], prev_y_r};
  assign neg_x  = -diff_x;
  assign neg_y  = -diff_y;

  assign dx_ext = SQ_BITS'(dx_r);
  assign dy_ext = SQ_BITS'(dy_r);
  assign sum_sq = SSQ_BITS'(sqx_r) + SSQ_BITS'(sqy_r);

  assign chord = start_r ? '0 : sq_root;

  always_comb begin
    state_nxt      = state_r;
    prev_x_nxt     = prev_x_r;
    prev_y_nxt     = prev_y_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    start_nxt      = start_r;
    sq_start       = 1'b0;
    acc_cmd.go     = 1'b0;
    acc_cmd.start  = start_r;
    in_chan.ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          prev_x_nxt = in_chan.x_coord;
          prev_y_nxt = in_chan.y_coord;
          dx_nxt     = diff_x[COORD_BITS] ? neg_x[COORD_BITS-1:0] : diff_x[COORD_BITS-1:0];
          dy_nxt     = diff_y[COORD_BITS] ? neg_y[COORD_BITS-1:0] : diff_y[COORD_BITS-1:0];
          start_nxt  = in_chan.start_line;
          state_nxt  = in_chan.start_line ? ST_SUM : ST_SQR;
        end
      end
      ST_SQR: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        sq_start  = 1'b1;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (!sq_busy) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        // hold until the result register can take a request
        if (acc_free) begin
          acc_cmd.go = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      prev_x_r <= '0;
      prev_y_r <= '0;
    end else begin
      state_r  <= state_nxt;
      prev_x_r <= prev_x_nxt;
      prev_y_r <= prev_y_nxt;
    end
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    start_r <= start_nxt;
    if (state_r == ST_SQR) begin
      sqx_r <= dx_ext * dx_ext;
      sqy_r <= dy_ext * dy_ext;
    end
  end

  pal_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (RAD_BITS'(sum_sq)),
    .busy     (sq_busy),
    .root     (sq_root)
  );

  pal_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (acc_cmd),
    .chord    (chord),
    .free     (acc_free),
    .out_chan (out_chan)
  );

endmodule

// ===== rtl/core/pal_isqrt.sv =====
module pal_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pal_pkg::RAD_BITS-1:0]  radicand,
  output logic                          busy,
  output logic [pal_pkg::ROOT_BITS-1:0] root
);
  import pal_pkg::*;

  logic [RAD_BITS-1:0]  rad_r, rad_nxt;
  logic [ROOT_BITS:0]   rem_r, rem_nxt;
  logic [ROOT_BITS-1:0] root_r, root_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [ROOT_BITS+2:0] lhs, rhs, trial;

  // one root bit per cycle, radicand consumed two bits at a time
  assign lhs   = {rem_r, rad_r[RAD_BITS-1 -: 2]};
  assign rhs   = {1'b0, root_r, 2'b01};
  assign trial = lhs - rhs;

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_BITS'(ROOT_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_BITS-3:0], 2'b00};
      if (!trial[ROOT_BITS+2]) begin
        rem_nxt  = trial[ROOT_BITS:0];
        root_nxt = {root_r[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_nxt  = lhs[ROOT_BITS:0];
        root_nxt = {root_r[ROOT_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_BITS'(1);
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

// ===== rtl/core/pal_accum.sv =====
module pal_accum (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pal_pkg::acc_cmd_t             cmd,
  input  logic [pal_pkg::ROOT_BITS-1:0] chord,
  output logic                          free,
  pal_out_if.source                     out_chan
);
  import pal_pkg::*;

  logic [SUM_BITS-1:0] run_r, run_nxt;
  logic                sat_r, sat_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SUM_BITS-1:0] out_len_r, out_len_nxt;
  logic                out_sat_r, out_sat_nxt;
  logic [ACC_BITS-1:0] total;
  logic                ovf;
  logic [SUM_BITS-1:0] sum;

  assign total = ACC_BITS'(run_r) + ACC_BITS'(chord);
  assign ovf   = total > SUM_MAX_EXT;
  assign sum   = ovf ? SUM_MAX : total[SUM_BITS-1:0];
  assign free  = !out_valid_r || out_chan.ready;

  always_comb begin
    run_nxt       = run_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_len_nxt   = out_len_r;
    out_sat_nxt   = out_sat_r;
    if (cmd.go) begin
      if (cmd.start) begin
        run_nxt       = '0;
        sat_nxt       = 1'b0;
        out_valid_nxt = 1'b1;
        out_len_nxt   = '0;
        out_sat_nxt   = 1'b0;
      end else begin
        run_nxt = sum;
        sat_nxt = sat_r | ovf;
        // drop the request when the length did not move
        if (sum != run_r) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = sum;
          out_sat_nxt   = sat_r | ovf;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      run_r       <= run_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_len_r <= out_len_nxt;
    out_sat_r <= out_sat_nxt;
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.arc_length       = out_len_r;
  assign out_chan.length_saturated = out_sat_r;

endmodule
